[rtl/wcad_pkg.sv]
package wcad_pkg;

  localparam int NODE_W   = 2;
  localparam int TEMP_W   = 12;
  localparam int ACCEL_W  = 15;
  localparam int SCORE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int CONS_W   = 2;
  localparam int RISE_W   = 11;
  localparam int SPIKE_W  = 14;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REGIDX_W = 3;

  localparam logic [REGIDX_W-1:0] REG_SCORE_ANOM  = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_SCORE_NORM  = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_CONSENSUS   = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_TEMP_RISE   = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_ACCEL_SPIKE = 3'd4;

  localparam logic [SCORE_W-1:0] RST_SCORE_ANOM  = 16'd60293;
  localparam logic [SCORE_W-1:0] RST_SCORE_NORM  = 16'd45875;
  localparam logic [CONS_W-1:0]  RST_CONSENSUS   = 2'd2;
  localparam logic [RISE_W-1:0]  RST_TEMP_RISE   = 11'd80;
  localparam logic [SPIKE_W-1:0] RST_ACCEL_SPIKE = 14'd1200;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_WARMUP  = 2'd0,
    STATUS_NORMAL  = 2'd1,
    STATUS_ANOMALY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score_anom;
    logic [SCORE_W-1:0] score_norm;
    logic [CONS_W-1:0]  consensus;
    logic [RISE_W-1:0]  temp_rise;
    logic [SPIKE_W-1:0] accel_spike;
  } cfg_t;

  typedef struct packed {
    logic win_v;
    logic sc_v;
    logic is_old;
    logic is_new;
  } scan_tag_t;

  typedef struct packed {
    logic anomaly;
    logic normal;
  } verdict_t;

endpackage

[rtl/wcad_ram.sv]
module wcad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/wcad_scan.sv]
module wcad_scan import wcad_pkg::*; #(
  parameter int HISTORY = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clr_i,
  input  scan_tag_t                 tag_i,
  input  logic signed [TEMP_W-1:0]  temp_i,
  input  logic signed [ACCEL_W-1:0] accel_i,
  input  logic [SCORE_W-1:0]        score_i,
  input  cfg_t                      cfg_i,
  output verdict_t                  verdict_o
);

  localparam int HCW = $clog2(HISTORY + 1);
  localparam int CW  = (HCW > CONS_W) ? HCW : CONS_W;

  logic [HCW-1:0]            hi_q, lo_q;
  logic [ACCEL_W-1:0]        peak_q;
  logic signed [TEMP_W-1:0]  t_old_q, t_new_q;
  logic [ACCEL_W-1:0]        mag;
  logic signed [TEMP_W:0]    rise;
  logic signed [TEMP_W:0]    rise_lim;

  // |accel|; the most negative code maps to 2^(ACCEL_W-1), which still fits unsigned
  assign mag = accel_i[ACCEL_W-1] ? (~accel_i + 1'b1) : accel_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q   <= '0;
      lo_q   <= '0;
      peak_q <= '0;
    end else if (clr_i) begin
      hi_q   <= '0;
      lo_q   <= '0;
      peak_q <= '0;
    end else begin
      if (tag_i.sc_v && (score_i > cfg_i.score_anom)) begin
        hi_q <= hi_q + 1'b1;
      end
      if (tag_i.sc_v && (score_i < cfg_i.score_norm)) begin
        lo_q <= lo_q + 1'b1;
      end
      if (tag_i.win_v && (mag > peak_q)) begin
        peak_q <= mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.win_v && tag_i.is_old) begin
      t_old_q <= temp_i;
    end
    if (tag_i.win_v && tag_i.is_new) begin
      t_new_q <= temp_i;
    end
  end

  assign rise     = $signed({t_new_q[TEMP_W-1], t_new_q}) - $signed({t_old_q[TEMP_W-1], t_old_q});
  assign rise_lim = $signed({2'b00, cfg_i.temp_rise});

  assign verdict_o.anomaly = (CW'(hi_q) >= CW'(cfg_i.consensus))
                          || (rise > rise_lim)
                          || (peak_q > ACCEL_W'(cfg_i.accel_spike));
  assign verdict_o.normal  = (lo_q >= HCW'(HISTORY - 1));

endmodule

[rtl/window_consensus_anomaly_detector_core.sv]
// Per-node k-of-n consensus anomaly detector with hysteresis. Each item carries a node
// number, temperature, acceleration and anomaly score and yields one result (status and
// held flag). For node 0, or a node number at or above NODES, the block goes from accept
// straight to the output state that loads the result; a warming-up node passes through
// the write state first. For a ready node, after the write of the new sample, the single
// read port of the sample memory is swept once over the node's window, the score memory
// being read in the same sweep, and one shared set of comparators folds in one entry per
// cycle, followed by the drain and decide states. The next item is accepted in the cycle
// after the result is loaded: no new item is taken before the last one is through. A result
// that has not been taken holds the block in its final state until the output register frees.
module window_consensus_anomaly_detector_core import wcad_pkg::*; #(
  parameter int WINDOW  = 12,
  parameter int HISTORY = 3,
  parameter int NODES   = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [NODE_W-1:0]         node_i,
  input  logic signed [TEMP_W-1:0]  temperature_i,
  input  logic signed [ACCEL_W-1:0] accel_i,
  input  logic [SCORE_W-1:0]        score_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic                      alert_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int NW     = $clog2(NODES);
  localparam int WPW    = $clog2(WINDOW);
  localparam int SPW    = $clog2(HISTORY);
  localparam int TW     = $clog2(HISTORY + 1);
  localparam int WDEPTH = NODES * WINDOW;
  localparam int SDEPTH = NODES * HISTORY;
  localparam int WA     = $clog2(WDEPTH);
  localparam int SA     = $clog2(SDEPTH);
  localparam int SCAN_N = (WINDOW > HISTORY) ? WINDOW : HISTORY;
  localparam int IW     = $clog2(SCAN_N);
  localparam int WDW    = TEMP_W + ACCEL_W;

  // configuration
  cfg_t                 cfg_q;
  logic                 cfg_we;
  logic [REGIDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_anom  <= RST_SCORE_ANOM;
      cfg_q.score_norm  <= RST_SCORE_NORM;
      cfg_q.consensus   <= RST_CONSENSUS;
      cfg_q.temp_rise   <= RST_TEMP_RISE;
      cfg_q.accel_spike <= RST_ACCEL_SPIKE;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCORE_ANOM:  cfg_q.score_anom  <= pwdata[SCORE_W-1:0];
        REG_SCORE_NORM:  cfg_q.score_norm  <= pwdata[SCORE_W-1:0];
        REG_CONSENSUS:   cfg_q.consensus   <= pwdata[CONS_W-1:0];
        REG_TEMP_RISE:   cfg_q.temp_rise   <= pwdata[RISE_W-1:0];
        REG_ACCEL_SPIKE: cfg_q.accel_spike <= pwdata[SPIKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SCORE_ANOM:  prdata = PDATA_W'(cfg_q.score_anom);
      REG_SCORE_NORM:  prdata = PDATA_W'(cfg_q.score_norm);
      REG_CONSENSUS:   prdata = PDATA_W'(cfg_q.consensus);
      REG_TEMP_RISE:   prdata = PDATA_W'(cfg_q.temp_rise);
      REG_ACCEL_SPIKE: prdata = PDATA_W'(cfg_q.accel_spike);
      default:         prdata = '0;
    endcase
  end

  // control and per-node state
  ctrl_state_e state_q, state_d;

  logic [WPW-1:0] wp_q     [NODES];
  logic           filled_q [NODES];
  logic [SPW-1:0] sp_q     [NODES];
  logic [TW-1:0]  tally_q  [NODES];
  logic           held_q   [NODES];

  logic [NW-1:0]              node_q;
  logic signed [TEMP_W-1:0]   temp_q;
  logic signed [ACCEL_W-1:0]  accel_q;
  logic [SCORE_W-1:0]         score_q;
  logic [WA-1:0]              wb_q;
  logic [SA-1:0]              hb_q;
  logic [WPW-1:0]             oldest_q, newest_q;
  logic [IW-1:0]              idx_q;
  logic                       warm_q;
  scan_tag_t                  tag_q;
  logic                       out_valid_q;
  status_e                    out_status_q;
  logic                       out_flag_q;

  logic           in_acc, node_ok, slot_free;
  logic [WPW-1:0] wp_cur, wp_new;
  logic [SPW-1:0] sp_cur, sp_new;
  logic [TW-1:0]  tally_cur, tally_new;
  logic           wp_wrap, filled_new, ready_new;
  logic           win_rd, sc_rd;
  logic [WA-1:0]  win_waddr, win_raddr;
  logic [SA-1:0]  sc_waddr, sc_raddr;
  logic [WDW-1:0] win_rdata;
  logic [SCORE_W-1:0] sc_rdata;
  verdict_t       verdict;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign node_ok    = (node_i != '0) && (32'(node_i) < NODES);
  assign slot_free  = !out_valid_q || out_ready_i;

  assign wp_cur     = wp_q[node_q];
  assign wp_wrap    = (wp_cur == WPW'(WINDOW - 1));
  assign wp_new     = wp_wrap ? '0 : wp_cur + 1'b1;
  assign filled_new = filled_q[node_q] || wp_wrap;
  assign sp_cur     = sp_q[node_q];
  assign sp_new     = (sp_cur == SPW'(HISTORY - 1)) ? '0 : sp_cur + 1'b1;
  assign tally_cur  = tally_q[node_q];
  assign tally_new  = (tally_cur == TW'(HISTORY)) ? tally_cur : tally_cur + 1'b1;
  assign ready_new  = filled_new && (tally_new == TW'(HISTORY));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = node_ok ? ST_WRITE : ST_OUT;
        end
      end
      ST_WRITE:  state_d = ready_new ? ST_SCAN : ST_OUT;
      ST_SCAN: begin
        if (idx_q == IW'(SCAN_N - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NODES; n++) begin
        wp_q[n]     <= '0;
        filled_q[n] <= 1'b0;
        sp_q[n]     <= '0;
        tally_q[n]  <= '0;
        held_q[n]   <= 1'b0;
      end
      idx_q       <= '0;
      warm_q      <= 1'b1;
      tag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tag_q.win_v  <= win_rd;
      tag_q.sc_v   <= sc_rd;
      tag_q.is_old <= (idx_q == IW'(oldest_q));
      tag_q.is_new <= (idx_q == IW'(newest_q));
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            warm_q <= !node_ok;
          end
        end
        ST_WRITE: begin
          wp_q[node_q]     <= wp_new;
          filled_q[node_q] <= filled_new;
          sp_q[node_q]     <= sp_new;
          tally_q[node_q]  <= tally_new;
          warm_q           <= !ready_new;
          idx_q            <= '0;
        end
        ST_SCAN: begin
          idx_q <= idx_q + 1'b1;
        end
        ST_DECIDE: begin
          if (verdict.anomaly) begin
            held_q[node_q] <= 1'b1;
          end else if (verdict.normal) begin
            held_q[node_q] <= 1'b0;
          end
        end
        default: ;
      endcase
      if (state_q == ST_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      node_q  <= NW'(node_i);
      temp_q  <= temperature_i;
      accel_q <= accel_i;
      score_q <= score_i;
      wb_q    <= WA'(32'(node_i) * WINDOW);
      hb_q    <= SA'(32'(node_i) * HISTORY);
    end
    if (state_q == ST_WRITE) begin
      oldest_q <= wp_new;
      newest_q <= (wp_new == '0) ? WPW'(WINDOW - 1) : wp_new - 1'b1;
    end
    if (state_q == ST_OUT && slot_free) begin
      if (warm_q) begin
        out_status_q <= STATUS_WARMUP;
        out_flag_q   <= 1'b0;
      end else begin
        out_status_q <= held_q[node_q] ? STATUS_ANOMALY : STATUS_NORMAL;
        out_flag_q   <= held_q[node_q];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign alert_o     = out_flag_q;

  // memories
  assign win_rd    = (state_q == ST_SCAN) && (32'(idx_q) < WINDOW);
  assign sc_rd     = (state_q == ST_SCAN) && (32'(idx_q) < HISTORY);
  assign win_waddr = wb_q + WA'(wp_cur);
  assign win_raddr = wb_q + WA'(idx_q);
  assign sc_waddr  = hb_q + SA'(sp_cur);
  assign sc_raddr  = hb_q + SA'(idx_q);

  wcad_ram #(
    .WIDTH (WDW),
    .DEPTH (WDEPTH)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WRITE),
    .waddr_i (win_waddr),
    .wdata_i ({temp_q, accel_q}),
    .re_i    (win_rd),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  wcad_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (SDEPTH)
  ) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WRITE),
    .waddr_i (sc_waddr),
    .wdata_i (score_q),
    .re_i    (sc_rd),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rdata)
  );

  wcad_scan #(
    .HISTORY (HISTORY)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (state_q == ST_WRITE),
    .tag_i     (tag_q),
    .temp_i    (win_rdata[WDW-1:ACCEL_W]),
    .accel_i   (win_rdata[ACCEL_W-1:0]),
    .score_i   (sc_rdata),
    .cfg_i     (cfg_q),
    .verdict_o (verdict)
  );

`ifndef NO_ASSERTIONS
  a_scan_only_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (filled_q[node_q] && (tally_q[node_q] == TW'(HISTORY))))
    else $error("scan on a node that is not ready");

  a_scan_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (32'(idx_q) < SCAN_N))
    else $error("scan index out of range");

  a_no_stray_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!tag_q.win_v && !tag_q.sc_v))
    else $error("read data tagged valid while idle");

  a_warmup_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_WARMUP)) |-> !alert_o)
    else $error("flag set on a warmup result");
`endif

endmodule

[tb/sv/window_consensus_anomaly_detector_core_tb.sv]
module window_consensus_anomaly_detector_core_tb;
  import wcad_pkg::*;

  localparam int WINDOW       = 12;
  localparam int HISTORY      = 3;
  localparam int NODES        = 4;
  localparam int RANDOM_ITEMS = 1400;
  localparam int PHASES       = 6;
  localparam int LIMIT        = 400000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    status_e status;
    logic    flag;
  } health_t;

  typedef struct {
    logic [NODE_W-1:0]         node;
    logic signed [TEMP_W-1:0]  temp;
    logic signed [ACCEL_W-1:0] accel;
    logic [SCORE_W-1:0]        score;
    bit                        typed;
    health_t                   want;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [NODE_W-1:0]         node = '0;
  logic signed [TEMP_W-1:0]  temperature = '0;
  logic signed [ACCEL_W-1:0] accel = '0;
  logic [SCORE_W-1:0]        score = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic                      alert;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [PADDR_W-1:0]        paddr = '0;
  logic [PDATA_W-1:0]        pwdata = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;

  // predictor copy of the configuration
  logic [SCORE_W-1:0] anom_thr  = RST_SCORE_ANOM;
  logic [SCORE_W-1:0] norm_thr  = RST_SCORE_NORM;
  logic [CONS_W-1:0]  cons_need = RST_CONSENSUS;
  logic [RISE_W-1:0]  rise_thr  = RST_TEMP_RISE;
  logic [SPIKE_W-1:0] spike_thr = RST_ACCEL_SPIKE;

  // predictor copy of the per-node detectors
  logic signed [TEMP_W-1:0]  temp_ring  [NODES][WINDOW];
  logic signed [ACCEL_W-1:0] accel_ring [NODES][WINDOW];
  logic [SCORE_W-1:0]        score_ring [NODES][HISTORY];
  int                        wr_pos     [NODES];
  int                        sc_pos     [NODES];
  int                        sc_count   [NODES];
  bit                        filled     [NODES];
  bit                        held       [NODES];

  health_t health_q[$];
  probe_t  rows[$];
  int      errors = 0;
  int      cycles = 0;
  int      rcv_mode = 0;
  int      stall_cnt = 0;

  window_consensus_anomaly_detector_core #(
    .WINDOW (WINDOW),
    .HISTORY(HISTORY),
    .NODES  (NODES)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .node_i        (node),
    .temperature_i (temperature),
    .accel_i       (accel),
    .score_i       (score),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .alert_o       (alert),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("window_consensus_anomaly_detector_core test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    stall_cnt <= (stall_cnt == 6) ? 0 : stall_cnt + 1;
    case (rcv_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= (stall_cnt >= 3);
    endcase
  end

  always @(posedge clk) begin : check_results
    health_t want;
    if (rst_n && out_valid && out_ready) begin
      if (health_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("result with nothing pending: status %0d flag %0d", status, alert);
      end else begin
        want = health_q.pop_front();
        if (status !== want.status || alert !== want.flag) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("mismatch: status exp %0d got %0d, flag exp %0d got %0d",
                     want.status, status, want.flag, alert);
        end
      end
    end
  end

  task automatic assess_node(input logic [NODE_W-1:0] n, input logic signed [TEMP_W-1:0] t,
                             input logic signed [ACCEL_W-1:0] a,
                             input logic [SCORE_W-1:0] s, output health_t h);
    int hi;
    int lo;
    int peak;
    int mag;
    int rise;
    int newest;
    bit alarm;
    hi = 0;
    lo = 0;
    peak = 0;
    h = '{STATUS_WARMUP, 1'b0};
    if (n == 0 || n >= NODES) return;
    temp_ring[n][wr_pos[n]] = t;
    accel_ring[n][wr_pos[n]] = a;
    wr_pos[n]++;
    if (wr_pos[n] == WINDOW) begin
      wr_pos[n] = 0;
      filled[n] = 1'b1;
    end
    score_ring[n][sc_pos[n]] = s;
    sc_pos[n] = (sc_pos[n] + 1) % HISTORY;
    if (sc_count[n] < HISTORY) sc_count[n]++;
    if (!filled[n] || sc_count[n] < HISTORY) return;
    for (int i = 0; i < HISTORY; i++) begin
      if (score_ring[n][i] > anom_thr) hi++;
      if (score_ring[n][i] < norm_thr) lo++;
    end
    for (int i = 0; i < WINDOW; i++) begin
      mag = int'(accel_ring[n][i]);
      if (mag < 0) mag = -mag;
      if (mag > peak) peak = mag;
    end
    // oldest sample sits at the write position
    newest = (wr_pos[n] + WINDOW - 1) % WINDOW;
    rise = int'(temp_ring[n][newest]) - int'(temp_ring[n][wr_pos[n]]);
    alarm = (hi >= int'(cons_need)) || (rise > int'(rise_thr)) || (peak > int'(spike_thr));
    if (alarm) held[n] = 1'b1;
    else if (lo >= HISTORY - 1) held[n] = 1'b0;
    h = held[n] ? '{STATUS_ANOMALY, 1'b1} : '{STATUS_NORMAL, 1'b0};
  endtask

  task automatic send_item(input probe_t p);
    health_t h;
    @(negedge clk);
    in_valid <= 1'b1;
    node <= p.node;
    temperature <= p.temp;
    accel <= p.accel;
    score <= p.score;
    do @(posedge clk); while (!in_ready);
    assess_node(p.node, p.temp, p.accel, p.score, h);
    health_q.push_back(p.typed ? p.want : h);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (health_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [REGIDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SCORE_ANOM:  anom_thr = val[SCORE_W-1:0];
      REG_SCORE_NORM:  norm_thr = val[SCORE_W-1:0];
      REG_CONSENSUS:   cons_need = val[CONS_W-1:0];
      REG_TEMP_RISE:   rise_thr = val[RISE_W-1:0];
      REG_ACCEL_SPIKE: spike_thr = val[SPIKE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_row(input int n, input int t, input int a, input int s, input bit typed,
                         input status_e st, input logic fl);
    probe_t p;
    p.node = NODE_W'(n);
    p.temp = TEMP_W'(t);
    p.accel = ACCEL_W'(a);
    p.score = SCORE_W'(s);
    p.typed = typed;
    p.want = '{st, fl};
    rows.push_back(p);
  endtask

  initial begin : stimulus
    probe_t p;
    int     temp_base [NODES];
    int     per_phase;
    int     burst_left;
    int     gap;
    int     sel;
    int     d;
    int     v;
    logic [PDATA_W-1:0] va, vn, vc, vr, vs;

    foreach (temp_ring[i, j]) begin
      temp_ring[i][j] = '0;
      accel_ring[i][j] = '0;
    end
    foreach (score_ring[i, j]) score_ring[i][j] = '0;
    foreach (wr_pos[i]) begin
      wr_pos[i] = 0;
      sc_pos[i] = 0;
      sc_count[i] = 0;
      filled[i] = 1'b0;
      held[i] = 1'b0;
      temp_base[i] = 200;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unassigned node, extreme fields
    add_row(0, 2047, -16384, 65535, 1, STATUS_WARMUP, 1'b0);
    add_row(0, -2048, 16383, 0, 1, STATUS_WARMUP, 1'b0);
    // node 1 fills its window; last sample makes a large rise
    for (int k = 0; k < WINDOW - 1; k++)
      add_row(1, (k == 0) ? -400 : 100 + k, (k == 3) ? 16383 : (k == 4) ? -16384 : k,
              (k == 0) ? 65535 : (k == 1) ? 0 : 30000, 1, STATUS_WARMUP, 1'b0);
    add_row(1, 1250, 16000, 30000, 1, STATUS_ANOMALY, 1'b1);
    add_row(2, 0, 0, 0, 1, STATUS_WARMUP, 1'b0);
    add_row(3, -400, -16000, 65535, 1, STATUS_WARMUP, 1'b0);
    add_row(1, 105, 10, 65535, 0, STATUS_WARMUP, 1'b0);
    add_row(1, 106, -5, 65535, 0, STATUS_WARMUP, 1'b0);
    foreach (rows[i]) send_item(rows[i]);

    per_phase = RANDOM_ITEMS / PHASES;
    burst_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: begin
            va = 0; vn = 65535; vc = 3; vr = 2047; vs = 16383;
          end
          2: begin
            va = 65535; vn = 0; vc = 1; vr = 0; vs = 0;
          end
          3: begin
            va = 50000; vn = 30000; vc = 0; vr = 40; vs = 3000;
          end
          4: begin
            va = $urandom_range(0, 65535);
            vn = $urandom_range(0, 65535);
            vc = $urandom_range(0, 3);
            vr = $urandom_range(0, 1650);
            vs = $urandom_range(0, 16000);
          end
          default: begin
            va = PDATA_W'(RST_SCORE_ANOM); vn = PDATA_W'(RST_SCORE_NORM);
            vc = PDATA_W'(RST_CONSENSUS);
            vr = PDATA_W'(RST_TEMP_RISE); vs = PDATA_W'(RST_ACCEL_SPIKE);
          end
        endcase
        set_reg(REG_SCORE_ANOM, va);
        set_reg(REG_SCORE_NORM, vn);
        set_reg(REG_CONSENSUS, vc);
        set_reg(REG_TEMP_RISE, vr);
        set_reg(REG_ACCEL_SPIKE, vs);
      end
      rcv_mode = ph % 3;

      for (int k = 0; k < per_phase; k++) begin
        if (k == per_phase / 2) wait_idle();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        burst_left--;

        p.typed = 1'b0;
        p.want = '{STATUS_WARMUP, 1'b0};
        p.node = NODE_W'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, NODES - 1));

        d = $urandom_range(0, 8);
        temp_base[p.node] += d - 4;
        sel = $urandom_range(0, 59);
        if (sel < 2) begin
          d = $urandom_range(0, 2 * int'(rise_thr) + 2);
          temp_base[p.node] += d - int'(rise_thr) - 1;
        end
        if (temp_base[p.node] < -400) temp_base[p.node] = -400;
        if (temp_base[p.node] > 1250) temp_base[p.node] = 1250;
        if (sel == 59) p.temp = TEMP_W'($urandom);
        else p.temp = TEMP_W'(temp_base[p.node]);

        sel = $urandom_range(0, 59);
        if (sel == 0) begin
          p.accel = ACCEL_W'($urandom);
        end else begin
          if (sel < 3) begin
            d = $urandom_range(0, 2);
            v = int'(spike_thr) + d - 1;
          end else begin
            v = $urandom_range(0, int'(spike_thr) * 9 / 10);
          end
          if ($urandom_range(0, 1) == 1) v = -v;
          p.accel = ACCEL_W'(v);
        end

        sel = $urandom_range(0, 5);
        d = $urandom_range(0, 2);
        case (sel)
          0: v = int'(anom_thr) + d - 1;
          1: v = int'(norm_thr) + d - 1;
          2: v = $urandom_range(0, int'(norm_thr));
          3: v = $urandom_range(int'(anom_thr), 65535);
          default: v = $urandom_range(0, 65535);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        p.score = SCORE_W'(v);

        send_item(p);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    errors += health_q.size();
    if (errors == 0) begin
      $display("window_consensus_anomaly_detector_core test passed");
    end else begin
      $display("window_consensus_anomaly_detector_core test failed");
    end
    $finish;
  end

endmodule
